@@ sv/mbe_pkg.sv @@
package mbe_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 28;
  localparam int ITER_BITS = 16;
  localparam int INT_BITS  = 4;

  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int DIM_W   = 13;
  localparam int DIV_W   = 16;
  localparam int Q_W     = FRAC_BITS + INT_BITS;
  localparam int P_W     = 2 * Q_W;
  localparam int X_W     = P_W - FRAC_BITS;
  localparam int S_W     = X_W + 1;
  localparam int CNT_W   = $clog2(Q_W);

  localparam logic [DIM_W-1:0]     RST_IMAGE_WIDTH    = DIM_W'(640);
  localparam logic [DIM_W-1:0]     RST_IMAGE_HEIGHT   = DIM_W'(480);
  localparam logic [ITER_BITS-1:0] RST_MAX_ITERATIONS = ITER_BITS'(256);

  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_MAX_ITERATIONS = 2'd2;

  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RE_START,
    ST_RE_WAIT,
    ST_IM_START,
    ST_IM_WAIT,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic div_sel_im;
    logic store_re;
    logic store_im;
    logic iter_mul;
    logic iter_add;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic limit_zero;
    logic iter_stop;
    logic out_free;
  } dp_status_t;

  function automatic logic [Q_W-1:0] sat_q(input logic signed [S_W-1:0] v);
    logic signed [S_W-1:0] hi;
    logic signed [S_W-1:0] lo;
    hi = {{(S_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
    lo = {{(S_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};
    if (v > hi) begin
      return Q_MAX;
    end else if (v < lo) begin
      return Q_MIN;
    end
    return v[Q_W-1:0];
  endfunction

endpackage

@@ sv/mbe_div.sv @@
module mbe_div import mbe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quot,
  output logic             rem_nz,
  output logic             sat
);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [DIV_W-1:0]    rem;
  logic [DIV_W-1:0]    den_q;
  logic [INT_BITS-1:0] nbits;
  logic [DIV_W:0]      trial;
  logic [DIV_W:0]      trial_diff;
  logic                ge;
  logic                sat_c;

  // restoring division, one quotient bit per cycle
  assign trial      = {rem, nbits[INT_BITS-1]};
  assign ge         = trial >= {1'b0, den_q};
  assign trial_diff = trial - {1'b0, den_q};
  assign sat_c      = {{INT_BITS{1'b0}}, num} >= {den, {INT_BITS{1'b0}}};
  assign rem_nz     = rem != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat   <= sat_c;
      den_q <= den;
      rem   <= sat_c ? '0 : DIV_W'(num >> INT_BITS);
      nbits <= num[INT_BITS-1:0];
    end else if (busy) begin
      rem   <= ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
      nbits <= {nbits[INT_BITS-2:0], 1'b0};
      quot  <= {quot[Q_W-2:0], ge};
    end
  end

endmodule

@@ sv/mbe_datapath.sv @@
module mbe_datapath import mbe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic [COORD_W-1:0]   pixel_col,
  input  logic [COORD_W-1:0]   pixel_row,
  input  logic [DIM_W-1:0]     image_width,
  input  logic [DIM_W-1:0]     image_height,
  input  logic [ITER_BITS-1:0] max_iterations,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [ITER_BITS-1:0] out_count,
  output logic                 out_inside
);

  localparam logic [Q_W+1:0]        TWO_Q   = (Q_W+2)'(2) << FRAC_BITS;
  localparam logic [Q_W:0]          EIGHT_Q = (Q_W+1)'(1) << (Q_W - 1);
  localparam logic signed [S_W-1:0] ESC_LIM = S_W'(4) << FRAC_BITS;

  logic [COORD_W-1:0]   col_q;
  logic [COORD_W-1:0]   row_q;
  logic [DIM_W-1:0]     w_eff;
  logic [DIM_W-1:0]     h_eff;
  logic [DIM_W-1:0]     twice_row;
  logic                 ci_neg;
  logic [DIM_W-1:0]     diff;
  logic [DIV_W-1:0]     num_re;
  logic [DIV_W-1:0]     num_im;
  logic [DIV_W-1:0]     den_im;
  logic [DIV_W-1:0]     div_num;
  logic [DIV_W-1:0]     div_den;
  logic                 div_done;
  logic [Q_W-1:0]       quot;
  logic                 rem_nz;
  logic                 div_sat;

  logic signed [Q_W+1:0] re_tmp;
  logic [Q_W-1:0]        cr_val;
  logic [Q_W-1:0]        ci_pos;
  logic [Q_W:0]          ci_mag;
  logic [Q_W:0]          ci_negv;
  logic [Q_W-1:0]        ci_val;

  logic signed [Q_W-1:0] cr;
  logic signed [Q_W-1:0] ci;
  logic signed [Q_W-1:0] zr;
  logic signed [Q_W-1:0] zi;
  logic signed [P_W-1:0] pxx;
  logic signed [P_W-1:0] pyy;
  logic signed [P_W-1:0] pxy;
  logic [ITER_BITS-1:0]  count;
  logic [ITER_BITS-1:0]  count_inc;

  logic signed [X_W-1:0] xx;
  logic signed [X_W-1:0] yy;
  logic signed [S_W-1:0] xy2;
  logic signed [S_W-1:0] mag_sum;
  logic signed [S_W-1:0] zr_sum;
  logic signed [S_W-1:0] zi_sum;
  logic                  escape;

  // point mapping operands; a zero dimension counts as one
  assign w_eff     = (image_width == '0) ? DIM_W'(1) : image_width;
  assign h_eff     = (image_height == '0) ? DIM_W'(1) : image_height;
  assign twice_row = {row_q, 1'b0};
  assign ci_neg    = twice_row < h_eff;
  assign diff      = ci_neg ? (h_eff - twice_row) : (twice_row - h_eff);
  assign num_re    = DIV_W'({col_q, 1'b0}) + DIV_W'(col_q);
  assign num_im    = DIV_W'({diff, 2'b00}) + DIV_W'({diff, 1'b0});
  assign den_im    = DIV_W'({h_eff, 2'b00}) + DIV_W'(h_eff);
  assign div_num   = cmd.div_sel_im ? num_im : num_re;
  assign div_den   = cmd.div_sel_im ? den_im : DIV_W'(w_eff);

  mbe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot),
    .rem_nz(rem_nz),
    .sat   (div_sat)
  );

  assign re_tmp  = $signed({2'b00, quot}) - $signed(TWO_Q);
  assign cr_val  = div_sat ? Q_MAX : sat_q(S_W'(re_tmp));
  assign ci_pos  = (div_sat || quot[Q_W-1]) ? Q_MAX : quot;
  assign ci_mag  = {1'b0, quot} + (Q_W+1)'(rem_nz);
  assign ci_negv = (Q_W+1)'(0) - ci_mag;
  always_comb begin
    if (!ci_neg) begin
      ci_val = ci_pos;
    end else if (div_sat || ci_mag > EIGHT_Q) begin
      ci_val = Q_MIN;
    end else begin
      ci_val = ci_negv[Q_W-1:0];
    end
  end

  // one iteration: products are registered in the multiply state, sums and bound check follow in the add state
  assign xx        = pxx[P_W-1:FRAC_BITS];
  assign yy        = pyy[P_W-1:FRAC_BITS];
  assign xy2       = pxy[P_W-1:FRAC_BITS-1];
  assign mag_sum   = S_W'(xx) + S_W'(yy);
  assign escape    = mag_sum > ESC_LIM;
  assign zr_sum    = S_W'(xx) - S_W'(yy) + S_W'(cr);
  assign zi_sum    = xy2 + S_W'(ci);
  assign count_inc = count + ITER_BITS'(1);

  assign status.div_done   = div_done;
  assign status.limit_zero = max_iterations == '0;
  assign status.iter_stop  = escape || (count_inc == max_iterations);
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      col_q <= pixel_col;
      row_q <= pixel_row;
      zr    <= '0;
      zi    <= '0;
      count <= '0;
    end
    if (cmd.store_re) begin
      cr <= cr_val;
    end
    if (cmd.store_im) begin
      ci <= ci_val;
    end
    if (cmd.iter_mul) begin
      pxx <= zr * zr;
      pyy <= zi * zi;
      pxy <= zr * zi;
    end
    if (cmd.iter_add && !escape) begin
      zr    <= sat_q(zr_sum);
      zi    <= sat_q(zi_sum);
      count <= count_inc;
    end
    if (cmd.load_out) begin
      out_count  <= count;
      out_inside <= count == max_iterations;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ sv/mbe_ctrl.sv @@
module mbe_ctrl import mbe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_RE_START;
      end
      ST_RE_START: state_next = ST_RE_WAIT;
      ST_RE_WAIT: begin
        if (status.div_done) state_next = ST_IM_START;
      end
      ST_IM_START: state_next = ST_IM_WAIT;
      ST_IM_WAIT: begin
        if (status.div_done) state_next = status.limit_zero ? ST_DONE : ST_MUL;
      end
      ST_MUL: state_next = ST_ADD;
      ST_ADD: state_next = status.iter_stop ? ST_DONE : ST_MUL;
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_RE_START: cmd.div_start = 1'b1;
      ST_RE_WAIT: cmd.store_re = status.div_done;
      ST_IM_START: begin
        cmd.div_start  = 1'b1;
        cmd.div_sel_im = 1'b1;
      end
      ST_IM_WAIT: begin
        cmd.div_sel_im = 1'b1;
        cmd.store_im   = status.div_done;
      end
      ST_MUL: cmd.iter_mul = 1'b1;
      ST_ADD: cmd.iter_add = 1'b1;
      ST_DONE: cmd.load_out = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ sv/mandelbrot_escape_time_pixel_unit.sv @@
// Per pixel: the real and then the imaginary coordinate divide, then multiply/add
// passes: N iterations, plus one more pass when the point escapes before the
// limit. One pixel at a time: a new pixel is accepted only after the previous
// result has been loaded into the output register.
// Reset (rst, synchronous): control idle, output empty, registers to
// 640 x 480 and 256 iterations.
module mandelbrot_escape_time_pixel_unit import mbe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [11:0] pixel_col, [23:12] pixel_row
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] iteration_count
  output logic        m_axis_tuser,   // [0] inside_set
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [DIM_W-1:0]     image_width;
  logic [DIM_W-1:0]     image_height;
  logic [ITER_BITS-1:0] max_iterations;
  logic                 cfg_write;
  dp_cmd_t              cmd;
  dp_status_t           status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
      max_iterations <= RST_MAX_ITERATIONS;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_IMAGE_WIDTH:    image_width    <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= pwdata[DIM_W-1:0];
        REG_MAX_ITERATIONS: max_iterations <= pwdata[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IMAGE_WIDTH:    prdata = 32'(image_width);
      REG_IMAGE_HEIGHT:   prdata = 32'(image_height);
      REG_MAX_ITERATIONS: prdata = 32'(max_iterations);
      default:            prdata = '0;
    endcase
  end

  mbe_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  mbe_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .pixel_col     (s_axis_tdata[COORD_W-1:0]),
    .pixel_row     (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .image_width   (image_width),
    .image_height  (image_height),
    .max_iterations(max_iterations),
    .out_ready     (m_axis_tready),
    .out_valid     (m_axis_tvalid),
    .out_count     (m_axis_tdata),
    .out_inside    (m_axis_tuser)
  );

endmodule

@@ sv/mbe_checker.sv @@
module mbe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        pready
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output item changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared right after accept");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind mandelbrot_escape_time_pixel_unit mbe_checker u_checker (.*);
